/* hw/rtl/brfd_pkg.sv */
// Package for the byte-run frame decoder.
// Holds the shared types, codes and fixed widths. No dependencies.
`timescale 1ns / 1ps

package brfd_pkg;

    localparam int DIM_W       = 13;
    localparam int POS_W       = 12;
    localparam int PIX_W       = 8;
    localparam int LEN_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int DIM_MAX     = (2 ** DIM_W) - 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 13'd320;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd200;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_HEADER    = 3'd1,
        ERR_COUNT     = 3'd2,
        ERR_REPVAL    = 3'd3,
        ERR_LIT_TRUNC = 3'd4,
        ERR_REP_OVF   = 3'd5,
        ERR_LIT_OVF   = 3'd6
    } t_err;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_COUNT   = 3'd2,
        PH_REPVAL  = 3'd3,
        PH_LITERAL = 3'd4
    } t_phase;

    typedef struct packed {
        logic [PIX_W-1:0] byte_value;
        logic             frame_start;
        logic             last_byte;
        logic             is_fill;
        logic [PIX_W-1:0] lit_count;
    } t_item;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_geom;

    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic [PIX_W-1:0] pixel_value;
        logic [LEN_W-1:0] run_length;
        logic             frame_done;
        t_err             error_code;
    } t_result;

endpackage

/* hw/rtl/brfd_ifs.sv */
// Channel interfaces of the byte-run frame decoder: input bytes,
// result items and configuration writes. Depends on brfd_pkg.
`timescale 1ns / 1ps

interface brfd_in_if;
    logic                     valid;
    logic                     ready;
    logic [brfd_pkg::PIX_W-1:0] byte_value;
    logic                     frame_start;
    logic                     last_byte;

    modport source (output valid, output byte_value, output frame_start,
                    output last_byte, input ready);
    modport sink   (input valid, input byte_value, input frame_start,
                    input last_byte, output ready);
endinterface

interface brfd_out_if;
    logic                       valid;
    logic                       ready;
    brfd_pkg::t_kind            kind;
    logic [brfd_pkg::POS_W-1:0] row;
    logic [brfd_pkg::POS_W-1:0] column;
    logic [brfd_pkg::PIX_W-1:0] pixel_value;
    logic [brfd_pkg::LEN_W-1:0] run_length;
    logic                       frame_done;
    brfd_pkg::t_err             error_code;

    modport source (output valid, output kind, output row, output column,
                    output pixel_value, output run_length, output frame_done,
                    output error_code, input ready);
    modport sink   (input valid, input kind, input row, input column,
                    input pixel_value, input run_length, input frame_done,
                    input error_code, output ready);
endinterface

interface brfd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [brfd_pkg::CFG_IDX_W-1:0] index;
    logic [brfd_pkg::DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/brfd_front.sv */
// Front end: accepts chunk bytes and classifies each count byte.
// Depends on brfd_pkg and brfd_in_if.
`timescale 1ns / 1ps

module brfd_front (
    brfd_in_if.sink          i_in,
    input  logic             i_queue_full,
    output logic             o_push,
    output brfd_pkg::t_item  o_item
);
    import brfd_pkg::*;

    assign i_in.ready = !i_queue_full;
    assign o_push     = i_in.valid && !i_queue_full;

    // A negative count byte b announces 256 - b literal bytes.
    always_comb begin
        o_item.byte_value  = i_in.byte_value;
        o_item.frame_start = i_in.frame_start;
        o_item.last_byte   = i_in.last_byte;
        o_item.is_fill     = !i_in.byte_value[PIX_W-1];
        o_item.lit_count   = (~i_in.byte_value) + PIX_W'(1);
    end

endmodule

/* hw/rtl/brfd_queue.sv */
// Short item queue between the front end and the decoder back end.
// Depends on brfd_pkg.
`timescale 1ns / 1ps

module brfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  brfd_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output brfd_pkg::t_item  o_item
);
    import brfd_pkg::*;

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + QUEUE_CNT_W'(1);
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* hw/rtl/brfd_back.sv */
// Back end: walks the frame row by row and registers at most one result per item.
// Depends on brfd_pkg and brfd_out_if.
`timescale 1ns / 1ps

module brfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  brfd_pkg::t_geom  i_geom,
    input  logic             i_valid,
    input  brfd_pkg::t_item  i_item,
    output logic             o_pop,
    brfd_out_if.source       o_out
);
    import brfd_pkg::*;

    t_phase             r_phase;
    t_phase             n_phase;
    logic [DIM_W-1:0]   r_row;
    logic [DIM_W-1:0]   n_row;
    logic [DIM_W-1:0]   r_col;
    logic [DIM_W-1:0]   n_col;
    logic [LEN_W-1:0]   r_pend;
    logic [LEN_W-1:0]   n_pend;
    logic               r_out_valid;
    t_result            r_out;

    t_phase             cur_ph;
    logic [DIM_W-1:0]   row_c;
    logic [DIM_W-1:0]   col_c;
    logic [DIM_W-1:0]   row_inc;
    logic [DIM_W:0]     sum;
    logic [PIX_W-1:0]   adv_n;
    logic               do_adv;
    logic               wrote;
    logic               fail;
    t_err               fail_code;
    logic               emit;
    t_result            res;

    assign o_pop = i_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        n_phase   = r_phase;
        n_row     = r_row;
        n_col     = r_col;
        n_pend    = r_pend;
        emit      = 1'b0;
        do_adv    = 1'b0;
        wrote     = 1'b0;
        adv_n     = '0;
        fail      = 1'b0;
        fail_code = ERR_NONE;
        sum       = '0;
        res       = '0;
        res.kind       = KIND_WRITE;
        res.error_code = ERR_NONE;
        row_c   = i_item.frame_start ? '0 : r_row;
        col_c   = i_item.frame_start ? '0 : r_col;
        cur_ph  = i_item.frame_start ? PH_HEADER : r_phase;
        row_inc = row_c + DIM_W'(1);

        if (i_item.frame_start) begin
            n_row  = '0;
            n_col  = '0;
            n_pend = '0;
        end

        if (i_item.frame_start && (i_geom.height == '0)) begin
            n_phase        = PH_IDLE;
            emit           = 1'b1;
            res.kind       = KIND_DONE;
            res.frame_done = 1'b1;
        end else begin
            unique case (cur_ph)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_HEADER: begin
                    if (i_geom.width == '0) begin
                        do_adv = 1'b1;
                    end else begin
                        n_phase = PH_COUNT;
                        if (i_item.last_byte) begin
                            fail      = 1'b1;
                            fail_code = ERR_COUNT;
                        end
                    end
                end
                PH_COUNT: begin
                    if (i_item.is_fill) begin
                        n_pend  = i_item.byte_value[LEN_W-1:0];
                        n_phase = PH_REPVAL;
                        if (i_item.last_byte) begin
                            fail      = 1'b1;
                            fail_code = ERR_REPVAL;
                        end
                    end else if ((col_c <= i_geom.width)
                                 && (({1'b0, col_c} + (DIM_W+1)'(i_item.lit_count))
                                     > {1'b0, i_geom.width})) begin
                        fail      = 1'b1;
                        fail_code = ERR_LIT_OVF;
                    end else if (i_item.last_byte) begin
                        fail      = 1'b1;
                        fail_code = ERR_LIT_TRUNC;
                    end else begin
                        n_pend  = LEN_W'(i_item.lit_count - PIX_W'(1));
                        n_phase = PH_LITERAL;
                    end
                end
                PH_REPVAL: begin
                    if ((col_c <= i_geom.width)
                        && (({1'b0, col_c} + (DIM_W+1)'(r_pend)) > {1'b0, i_geom.width}))
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_REP_OVF;
                    end else begin
                        emit            = 1'b1;
                        wrote           = 1'b1;
                        res.row         = row_c[POS_W-1:0];
                        res.column      = col_c[POS_W-1:0];
                        res.pixel_value = i_item.byte_value;
                        res.run_length  = r_pend;
                        do_adv          = 1'b1;
                        adv_n           = PIX_W'(r_pend);
                    end
                end
                PH_LITERAL: begin
                    if ((r_pend != '0) && i_item.last_byte) begin
                        fail      = 1'b1;
                        fail_code = ERR_LIT_TRUNC;
                    end else begin
                        emit            = 1'b1;
                        wrote           = 1'b1;
                        res.row         = row_c[POS_W-1:0];
                        res.column      = col_c[POS_W-1:0];
                        res.pixel_value = i_item.byte_value;
                        res.run_length  = LEN_W'(1);
                        if (r_pend != '0) begin
                            n_pend = r_pend - LEN_W'(1);
                            n_col  = col_c + DIM_W'(1);
                        end else begin
                            do_adv = 1'b1;
                            adv_n  = PIX_W'(1);
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            if (do_adv) begin
                sum = {1'b0, col_c} + (DIM_W+1)'(adv_n);
                if (sum >= {1'b0, i_geom.width}) begin
                    n_col   = '0;
                    n_row   = row_inc;
                    n_phase = PH_HEADER;
                    if (row_inc >= i_geom.height) begin
                        n_phase        = PH_IDLE;
                        emit           = 1'b1;
                        res.frame_done = 1'b1;
                        if (!wrote) begin
                            res.kind   = KIND_DONE;
                            res.row    = row_inc[POS_W-1:0];
                            res.column = '0;
                        end
                    end else if (i_item.last_byte) begin
                        fail      = 1'b1;
                        fail_code = ERR_HEADER;
                    end
                end else begin
                    n_col   = sum[DIM_W-1:0];
                    n_phase = PH_COUNT;
                    if (i_item.last_byte) begin
                        fail      = 1'b1;
                        fail_code = ERR_COUNT;
                    end
                end
            end

            if (fail) begin
                n_phase        = PH_IDLE;
                emit           = 1'b1;
                res            = '0;
                res.kind       = KIND_ERROR;
                res.row        = n_row[POS_W-1:0];
                res.column     = n_col[POS_W-1:0];
                res.error_code = fail_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_row   <= n_row;
                r_col   <= n_col;
                r_pend  <= n_pend;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.row         = r_out.row;
    assign o_out.column      = r_out.column;
    assign o_out.pixel_value = r_out.pixel_value;
    assign o_out.run_length  = r_out.run_length;
    assign o_out.frame_done  = r_out.frame_done;
    assign o_out.error_code  = r_out.error_code;

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && emit && ((res.kind != KIND_WRITE) || res.frame_done))
        |=> (r_phase == PH_IDLE))
        else $error("decoder not idle after frame end or error");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_ERROR))
        |-> ((r_out.error_code != ERR_NONE) && (r_out.run_length == '0)
             && !r_out.frame_done))
        else $error("malformed error item");

    a_ignored_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_item.frame_start && (r_phase == PH_IDLE)) |-> !emit)
        else $error("result from an ignored byte");

endmodule

/* hw/rtl/byte_run_frame_decoder_unit.sv */
// A byte's result passes through the queue, then the result register, before it is valid.
// Throughput: one byte per cycle while the four-entry queue has room; the decoder takes one
// queued item each cycle that the result register is free or draining, and the queue absorbs stalls.
// Reset (synchronous, active low) empties the queue and the result register, returns the
// decoder to idle awaiting a frame start, and sets the geometry to 320 by 200.
`timescale 1ns / 1ps

module byte_run_frame_decoder_unit #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brfd_in_if.sink     i_in,
    brfd_cfg_if.sink    i_cfg,
    brfd_out_if.source  o_out
);
    import brfd_pkg::*;

    localparam int unsigned WIDTH_CAP  = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int unsigned HEIGHT_CAP = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
    localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(WIDTH_CAP);
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(HEIGHT_CAP);

    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    t_geom            geom;
    logic             push;
    logic             queue_full;
    t_item            front_item;
    logic             queue_valid;
    t_item            queue_item;
    logic             pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        geom.width  = (r_frame_width > WIDTH_LIMIT) ? WIDTH_LIMIT : r_frame_width;
        geom.height = (r_frame_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : r_frame_height;
    end

    brfd_front u_front (
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    brfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    brfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_valid (queue_valid),
        .i_item  (queue_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
